// File: rtl/gvff_pkg.sv
// ---------------------------------------------------------------------------
// gvff_pkg
// shared types and constants of the grid voltage/frequency fault qualifier
// ---------------------------------------------------------------------------
package gvff_pkg;

  localparam int unsigned RMS_W  = 15;
  localparam int unsigned FREQ_W = 16;
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned DLY_W  = 2;
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned IDX_W  = 3;

  // qualification counts and delays
  localparam logic [CNT_W-1:0]  FAULT_TICKS    = 7'd10;
  localparam logic [CNT_W-1:0]  RECOVER_TICKS  = 7'd125;
  localparam logic [DLY_W-1:0]  EVENT_DELAY    = 2'd3;
  localparam logic [RMS_W-1:0]  FREQ_GATE_VOLT = 15'd500;

  // item kinds
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_ZC   = 1'b1;

  // register reset values
  localparam logic [RMS_W-1:0]  RMS_HIGH_FAULT_RST    = 15'd2700;
  localparam logic [RMS_W-1:0]  RMS_LOW_FAULT_RST     = 15'd800;
  localparam logic [RMS_W-1:0]  RMS_HIGH_RECOVER_RST  = 15'd2650;
  localparam logic [RMS_W-1:0]  RMS_LOW_RECOVER_RST   = 15'd850;
  localparam logic [FREQ_W-1:0] FREQ_HIGH_FAULT_RST   = 16'd650;
  localparam logic [FREQ_W-1:0] FREQ_LOW_FAULT_RST    = 16'd450;
  localparam logic [FREQ_W-1:0] FREQ_HIGH_RECOVER_RST = 16'd640;
  localparam logic [FREQ_W-1:0] FREQ_LOW_RECOVER_RST  = 16'd460;

  // register index map
  typedef enum logic [IDX_W-1:0] {
    REG_RMS_HIGH_FAULT    = 3'd0,
    REG_RMS_LOW_FAULT     = 3'd1,
    REG_RMS_HIGH_RECOVER  = 3'd2,
    REG_RMS_LOW_RECOVER   = 3'd3,
    REG_FREQ_HIGH_FAULT   = 3'd4,
    REG_FREQ_LOW_FAULT    = 3'd5,
    REG_FREQ_HIGH_RECOVER = 3'd6,
    REG_FREQ_LOW_RECOVER  = 3'd7
  } gvff_reg_t;

  // one set of window thresholds, widened to the frequency width
  typedef struct packed {
    logic [FREQ_W-1:0] hi_fault;
    logic [FREQ_W-1:0] lo_fault;
    logic [FREQ_W-1:0] hi_recover;
    logic [FREQ_W-1:0] lo_recover;
  } gvff_win_t;

  // hysteresis counter and fault flag
  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic             flag;
  } gvff_qual_t;

endpackage

// File: rtl/gvff_ifs.sv
// ---------------------------------------------------------------------------
// gvff channel interfaces
// valid/ready channels for monitor items and qualified results
// ---------------------------------------------------------------------------
interface gvff_in_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [gvff_pkg::RMS_W-1:0]    rms_volt;
  logic [gvff_pkg::FREQ_W-1:0]   line_freq;
  logic                          wave_fault;

  modport source (output valid, kind, rms_volt, line_freq, wave_fault, input ready);
  modport sink   (input valid, kind, rms_volt, line_freq, wave_fault, output ready);
endinterface

interface gvff_out_if;
  logic valid;
  logic ready;
  logic volt_fault;
  logic freq_fault;
  logic grid_ok;
  logic restore_event;
  logic lost_event;

  modport source (output valid, volt_fault, freq_fault, grid_ok, restore_event, lost_event,
                  input ready);
  modport sink   (input valid, volt_fault, freq_fault, grid_ok, restore_event, lost_event,
                  output ready);
endinterface

// File: rtl/gvff_cfg.sv
// ---------------------------------------------------------------------------
// gvff_cfg
// threshold register file, write only
// ---------------------------------------------------------------------------
module gvff_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [gvff_pkg::IDX_W-1:0]   cfg_idx,
  input  logic [gvff_pkg::CFG_W-1:0]   cfg_data,
  output gvff_pkg::gvff_win_t          volt_win,
  output gvff_pkg::gvff_win_t          freq_win
);

  logic [gvff_pkg::RMS_W-1:0]  rms_hf_r, rms_lf_r, rms_hr_r, rms_lr_r;
  logic [gvff_pkg::FREQ_W-1:0] frq_hf_r, frq_lf_r, frq_hr_r, frq_lr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rms_hf_r <= gvff_pkg::RMS_HIGH_FAULT_RST;
      rms_lf_r <= gvff_pkg::RMS_LOW_FAULT_RST;
      rms_hr_r <= gvff_pkg::RMS_HIGH_RECOVER_RST;
      rms_lr_r <= gvff_pkg::RMS_LOW_RECOVER_RST;
      frq_hf_r <= gvff_pkg::FREQ_HIGH_FAULT_RST;
      frq_lf_r <= gvff_pkg::FREQ_LOW_FAULT_RST;
      frq_hr_r <= gvff_pkg::FREQ_HIGH_RECOVER_RST;
      frq_lr_r <= gvff_pkg::FREQ_LOW_RECOVER_RST;
    end else if (cfg_we) begin
      case (gvff_pkg::gvff_reg_t'(cfg_idx))
        gvff_pkg::REG_RMS_HIGH_FAULT:    rms_hf_r <= cfg_data[gvff_pkg::RMS_W-1:0];
        gvff_pkg::REG_RMS_LOW_FAULT:     rms_lf_r <= cfg_data[gvff_pkg::RMS_W-1:0];
        gvff_pkg::REG_RMS_HIGH_RECOVER:  rms_hr_r <= cfg_data[gvff_pkg::RMS_W-1:0];
        gvff_pkg::REG_RMS_LOW_RECOVER:   rms_lr_r <= cfg_data[gvff_pkg::RMS_W-1:0];
        gvff_pkg::REG_FREQ_HIGH_FAULT:   frq_hf_r <= cfg_data;
        gvff_pkg::REG_FREQ_LOW_FAULT:    frq_lf_r <= cfg_data;
        gvff_pkg::REG_FREQ_HIGH_RECOVER: frq_hr_r <= cfg_data;
        gvff_pkg::REG_FREQ_LOW_RECOVER:  frq_lr_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // rms thresholds widened so both windows share one comparator layout
  assign volt_win.hi_fault   = {1'b0, rms_hf_r};
  assign volt_win.lo_fault   = {1'b0, rms_lf_r};
  assign volt_win.hi_recover = {1'b0, rms_hr_r};
  assign volt_win.lo_recover = {1'b0, rms_lr_r};
  assign freq_win.hi_fault   = frq_hf_r;
  assign freq_win.lo_fault   = frq_lf_r;
  assign freq_win.hi_recover = frq_hr_r;
  assign freq_win.lo_recover = frq_lr_r;

endmodule

// File: rtl/gvff_window.sv
// ---------------------------------------------------------------------------
// gvff_window
// one hysteresis qualification step: fault window, recovery window, counter
// ---------------------------------------------------------------------------
module gvff_window (
  input  logic [gvff_pkg::FREQ_W-1:0] sample,
  input  gvff_pkg::gvff_win_t         win,
  input  gvff_pkg::gvff_qual_t        cur,
  output gvff_pkg::gvff_qual_t        nxt
);

  logic                         hit;
  logic [gvff_pkg::CNT_W-1:0]   limit;
  logic [gvff_pkg::CNT_W-1:0]   cnt_inc;

  always_comb begin
    if (!cur.flag) begin
      hit   = (sample > win.hi_fault) || (sample < win.lo_fault);
      limit = gvff_pkg::FAULT_TICKS;
    end else begin
      hit   = (sample <= win.hi_recover) && (sample >= win.lo_recover);
      limit = gvff_pkg::RECOVER_TICKS;
    end
    // counter wraps at its own width
    cnt_inc = hit ? (cur.cnt + 7'd1) : '0;
    if (cnt_inc >= limit) begin
      nxt.cnt  = '0;
      nxt.flag = !cur.flag;
    end else begin
      nxt.cnt  = cnt_inc;
      nxt.flag = cur.flag;
    end
  end

endmodule

// File: rtl/grid_volt_freq_fault_qualifier.sv
// ---------------------------------------------------------------------------
// grid_volt_freq_fault_qualifier
// grid voltage and frequency window monitor with delayed restore/lost events
// ---------------------------------------------------------------------------
// Every input transfer (a check tick or a zero crossing) yields exactly one
// result transfer. An item is captured in an input register, and in the next
// cycle that it can move on, one pass of compare and counter logic updates the
// monitor state and loads the result register. A new item is taken every cycle
// (one item per clock) unless the result register holds an untaken result and
// the input register is also full. The user must write thresholds through the cfg
// port only while no item is in flight; the block does not enforce this.
// indexes 0..3 are the rms fault/recover limits, 4..7 the frequency ones.
// ---------------------------------------------------------------------------
module grid_volt_freq_fault_qualifier (
  input  logic                         clk,
  input  logic                         rst_n,
  gvff_in_if.sink                      in_ch,
  gvff_out_if.source                   out_ch,
  input  logic                         cfg_we,
  input  logic [gvff_pkg::IDX_W-1:0]   cfg_idx,
  input  logic [gvff_pkg::CFG_W-1:0]   cfg_data
);

  // threshold registers
  gvff_pkg::gvff_win_t volt_win, freq_win;

  gvff_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .volt_win (volt_win),
    .freq_win (freq_win)
  );

  // input register stage
  logic                          s1_vld_r;
  logic                          s1_kind_r;
  logic [gvff_pkg::RMS_W-1:0]    s1_rms_r;
  logic [gvff_pkg::FREQ_W-1:0]   s1_freq_r;
  logic                          s1_wave_r;
  logic                          out_vld_r;
  logic                          advance;
  logic                          in_xfer;

  // the item in the input register moves on when the result register frees up
  assign advance     = s1_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !s1_vld_r || advance;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_xfer) begin
      s1_vld_r <= 1'b1;
    end else if (advance) begin
      s1_vld_r <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_kind_r <= in_ch.kind;
      s1_rms_r  <= in_ch.rms_volt;
      s1_freq_r <= in_ch.line_freq;
      s1_wave_r <= in_ch.wave_fault;
    end
  end

  // monitor state
  logic [gvff_pkg::CNT_W-1:0] volt_cnt_r, freq_cnt_r;
  logic                       volt_flt_r, freq_flt_r, ok_prev_r;
  logic                       rst_pend_r, lost_pend_r;
  logic [gvff_pkg::DLY_W-1:0] rst_dly_r, lost_dly_r;

  logic [gvff_pkg::CNT_W-1:0] volt_cnt_nxt, freq_cnt_nxt;
  logic                       volt_flt_nxt, freq_flt_nxt, ok_prev_nxt;
  logic                       rst_pend_nxt, lost_pend_nxt;
  logic [gvff_pkg::DLY_W-1:0] rst_dly_nxt, lost_dly_nxt;
  logic                       rst_ev_nxt, lost_ev_nxt;

  // window qualification for voltage and frequency
  gvff_pkg::gvff_qual_t volt_cur, volt_q, freq_cur, freq_q;

  assign volt_cur.cnt  = volt_cnt_r;
  assign volt_cur.flag = volt_flt_r;
  assign freq_cur.cnt  = freq_cnt_r;
  assign freq_cur.flag = freq_flt_r;

  gvff_window u_volt_win (
    .sample ({1'b0, s1_rms_r}),
    .win    (volt_win),
    .cur    (volt_cur),
    .nxt    (volt_q)
  );

  gvff_window u_freq_win (
    .sample (s1_freq_r),
    .win    (freq_win),
    .cur    (freq_cur),
    .nxt    (freq_q)
  );

  logic                       freq_gated;
  logic                       ok_now;
  logic [gvff_pkg::DLY_W-1:0] rst_dly_inc, lost_dly_inc;

  // frequency is not judged while the voltage is too low to measure it
  assign freq_gated = s1_rms_r < gvff_pkg::FREQ_GATE_VOLT;

  always_comb begin
    volt_cnt_nxt  = volt_cnt_r;
    volt_flt_nxt  = volt_flt_r;
    freq_cnt_nxt  = freq_cnt_r;
    freq_flt_nxt  = freq_flt_r;
    ok_prev_nxt   = ok_prev_r;
    rst_pend_nxt  = rst_pend_r;
    rst_dly_nxt   = rst_dly_r;
    lost_pend_nxt = lost_pend_r;
    lost_dly_nxt  = lost_dly_r;
    rst_ev_nxt    = 1'b0;
    lost_ev_nxt   = 1'b0;
    ok_now        = 1'b0;
    rst_dly_inc   = '0;
    lost_dly_inc  = '0;

    if (s1_kind_r == gvff_pkg::KIND_ZC) begin
      // zero crossing: pending events fire now, flags stay
      if (rst_pend_r) begin
        rst_pend_nxt = 1'b0;
        rst_dly_nxt  = '0;
        rst_ev_nxt   = 1'b1;
      end
      if (lost_pend_r) begin
        lost_pend_nxt = 1'b0;
        lost_dly_nxt  = '0;
        lost_ev_nxt   = 1'b1;
      end
    end else begin
      volt_cnt_nxt = volt_q.cnt;
      volt_flt_nxt = volt_q.flag;
      if (freq_gated) begin
        freq_cnt_nxt = '0;
        freq_flt_nxt = 1'b0;
      end else begin
        freq_cnt_nxt = freq_q.cnt;
        freq_flt_nxt = freq_q.flag;
      end

      ok_now = !(volt_flt_nxt || freq_flt_nxt || s1_wave_r);

      // grid-ok rising edge arms a restore event
      if (ok_now && !ok_prev_r) begin
        rst_pend_nxt = 1'b1;
        rst_dly_nxt  = '0;
      end
      // grid-ok falling edge forces a full voltage recovery and arms lost
      if (!ok_now && ok_prev_r) begin
        volt_cnt_nxt  = '0;
        volt_flt_nxt  = 1'b1;
        lost_pend_nxt = 1'b1;
        lost_dly_nxt  = '0;
      end
      ok_prev_nxt = ok_now;

      // event delays count ticks, including the arming tick
      if (!rst_pend_nxt) begin
        rst_dly_nxt = '0;
      end else begin
        rst_dly_inc = rst_dly_nxt + 2'd1;
        if (rst_dly_inc >= gvff_pkg::EVENT_DELAY) begin
          rst_dly_nxt  = '0;
          rst_pend_nxt = 1'b0;
          rst_ev_nxt   = 1'b1;
        end else begin
          rst_dly_nxt = rst_dly_inc;
        end
      end

      if (!lost_pend_nxt) begin
        lost_dly_nxt = '0;
      end else begin
        lost_dly_inc = lost_dly_nxt + 2'd1;
        if (lost_dly_inc >= gvff_pkg::EVENT_DELAY) begin
          lost_dly_nxt  = '0;
          lost_pend_nxt = 1'b0;
          lost_ev_nxt   = 1'b1;
        end else begin
          lost_dly_nxt = lost_dly_inc;
        end
      end
    end
  end

  // state update together with result load
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      volt_cnt_r  <= '0;
      freq_cnt_r  <= '0;
      volt_flt_r  <= 1'b0;
      freq_flt_r  <= 1'b0;
      ok_prev_r   <= 1'b0;
      rst_pend_r  <= 1'b0;
      rst_dly_r   <= '0;
      lost_pend_r <= 1'b0;
      lost_dly_r  <= '0;
    end else if (advance) begin
      volt_cnt_r  <= volt_cnt_nxt;
      freq_cnt_r  <= freq_cnt_nxt;
      volt_flt_r  <= volt_flt_nxt;
      freq_flt_r  <= freq_flt_nxt;
      ok_prev_r   <= ok_prev_nxt;
      rst_pend_r  <= rst_pend_nxt;
      rst_dly_r   <= rst_dly_nxt;
      lost_pend_r <= lost_pend_nxt;
      lost_dly_r  <= lost_dly_nxt;
    end
  end

  // result register
  logic out_vf_r, out_ff_r, out_ok_r, out_rst_r, out_lost_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_vf_r   <= volt_flt_nxt;
      out_ff_r   <= freq_flt_nxt;
      out_ok_r   <= ok_prev_nxt;
      out_rst_r  <= rst_ev_nxt;
      out_lost_r <= lost_ev_nxt;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.volt_fault    = out_vf_r;
  assign out_ch.freq_fault    = out_ff_r;
  assign out_ch.grid_ok       = out_ok_r;
  assign out_ch.restore_event = out_rst_r;
  assign out_ch.lost_event    = out_lost_r;

`ifndef SYNTHESIS
  // an armed event always fires before its delay reaches the limit
  a_dly_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_dly_r < gvff_pkg::EVENT_DELAY) && (lost_dly_r < gvff_pkg::EVENT_DELAY))
    else $error("event delay counter reached its limit");

  // without a fault the count must stay below the fault limit
  a_volt_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    !volt_flt_r |-> (volt_cnt_r < gvff_pkg::FAULT_TICKS))
    else $error("voltage count past fault limit while no fault");

  // grid-ok can only be held while neither qualified fault is set
  a_ok_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    ok_prev_r |-> (!volt_flt_r && !freq_flt_r))
    else $error("grid ok held with a qualified fault set");

  // a result is loaded exactly when the input stage hands an item on
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_vld_r)
    else $error("handed-on item did not reach the result register");
`endif

endmodule

// File: tb/grid_volt_freq_fault_qualifier_tb.sv
// ---------------------------------------------------------------------------
// grid_volt_freq_fault_qualifier_tb
// self-checking bench for the grid voltage/frequency fault qualifier: a
// status tracker mirrors the window hysteresis, the frequency gate and the
// delayed restore/lost events, and every result transfer is checked against
// it while thresholds move through several settings and both sides idle
// ---------------------------------------------------------------------------
module grid_volt_freq_fault_qualifier_tb;
  import gvff_pkg::*;

  // one monitor item and one qualified status, at the block's widths
  typedef struct packed {
    logic              kind;
    logic [RMS_W-1:0]  rms;
    logic [FREQ_W-1:0] freq;
    logic              wave;
  } mon_item_t;

  typedef struct packed {
    logic volt_fault;
    logic freq_fault;
    logic grid_ok;
    logic restore_ev;
    logic lost_ev;
  } grid_status_t;

  typedef logic [CFG_W-1:0] thr_set_t [8];

  // tracks the monitor state and holds the statuses still to come out
  class status_tracker;
    logic [FREQ_W-1:0] thr [8];
    logic [CNT_W-1:0]  volt_cnt, freq_cnt;
    logic              volt_flt, freq_flt, ok_prev, rest_pend, lost_pend;
    logic [DLY_W-1:0]  rest_dly, lost_dly;
    grid_status_t      expected_q [$];
    int unsigned       errors;

    function new();
      thr[REG_RMS_HIGH_FAULT]    = {1'b0, RMS_HIGH_FAULT_RST};
      thr[REG_RMS_LOW_FAULT]     = {1'b0, RMS_LOW_FAULT_RST};
      thr[REG_RMS_HIGH_RECOVER]  = {1'b0, RMS_HIGH_RECOVER_RST};
      thr[REG_RMS_LOW_RECOVER]   = {1'b0, RMS_LOW_RECOVER_RST};
      thr[REG_FREQ_HIGH_FAULT]   = FREQ_HIGH_FAULT_RST;
      thr[REG_FREQ_LOW_FAULT]    = FREQ_LOW_FAULT_RST;
      thr[REG_FREQ_HIGH_RECOVER] = FREQ_HIGH_RECOVER_RST;
      thr[REG_FREQ_LOW_RECOVER]  = FREQ_LOW_RECOVER_RST;
      volt_cnt = '0; freq_cnt = '0;
      volt_flt = 1'b0; freq_flt = 1'b0; ok_prev = 1'b0;
      rest_pend = 1'b0; lost_pend = 1'b0;
      rest_dly = '0; lost_dly = '0;
      errors = 0;
    endfunction

    // rms limits keep only 15 bits
    function void set_threshold(gvff_reg_t idx, logic [CFG_W-1:0] val);
      if (idx <= REG_RMS_LOW_RECOVER) begin
        thr[idx] = {1'b0, val[RMS_W-1:0]};
      end else begin
        thr[idx] = val;
      end
    endfunction

    // one hysteresis step: count toward fault, or toward recovery once faulted
    function void step_window(input logic [FREQ_W-1:0] v, hi_f, lo_f, hi_r, lo_r,
                              inout logic [CNT_W-1:0] cnt, inout logic flag);
      logic             hit;
      logic [CNT_W-1:0] limit;
      if (!flag) begin
        hit   = (v > hi_f) || (v < lo_f);
        limit = FAULT_TICKS;
      end else begin
        hit   = (v <= hi_r) && (v >= lo_r);
        limit = RECOVER_TICKS;
      end
      cnt = hit ? cnt + 1'b1 : '0;
      if (cnt >= limit) begin
        cnt  = '0;
        flag = !flag;
      end
    endfunction

    function logic event_due(inout logic pend, inout logic [DLY_W-1:0] dly);
      if (!pend) begin
        dly = '0;
        return 1'b0;
      end
      dly = dly + 1'b1;
      if (dly >= EVENT_DELAY) begin
        dly  = '0;
        pend = 1'b0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_item(mon_item_t it);
      grid_status_t st;
      logic         ok_now;
      st = '0;
      if (it.kind == KIND_ZC) begin
        if (rest_pend) begin
          rest_pend = 1'b0; rest_dly = '0; st.restore_ev = 1'b1;
        end
        if (lost_pend) begin
          lost_pend = 1'b0; lost_dly = '0; st.lost_ev = 1'b1;
        end
      end else begin
        step_window({1'b0, it.rms}, thr[REG_RMS_HIGH_FAULT], thr[REG_RMS_LOW_FAULT],
                    thr[REG_RMS_HIGH_RECOVER], thr[REG_RMS_LOW_RECOVER],
                    volt_cnt, volt_flt);
        if (it.rms < FREQ_GATE_VOLT) begin
          freq_cnt = '0;
          freq_flt = 1'b0;
        end else begin
          step_window(it.freq, thr[REG_FREQ_HIGH_FAULT], thr[REG_FREQ_LOW_FAULT],
                      thr[REG_FREQ_HIGH_RECOVER], thr[REG_FREQ_LOW_RECOVER],
                      freq_cnt, freq_flt);
        end
        ok_now = !(volt_flt || freq_flt || it.wave);
        if (ok_now && !ok_prev) begin
          rest_dly = '0; rest_pend = 1'b1;
        end
        if (!ok_now && ok_prev) begin
          volt_cnt = '0; volt_flt = 1'b1;
          lost_dly = '0; lost_pend = 1'b1;
        end
        ok_prev       = ok_now;
        st.restore_ev = event_due(rest_pend, rest_dly);
        st.lost_ev    = event_due(lost_pend, lost_dly);
      end
      st.volt_fault = volt_flt;
      st.freq_fault = freq_flt;
      st.grid_ok    = ok_prev;
      expected_q.push_back(st);
    endfunction

    function void check_status(grid_status_t got);
      grid_status_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected status transfer: vf=%0b ff=%0b ok=%0b rst=%0b lost=%0b",
                   got.volt_fault, got.freq_fault, got.grid_ok, got.restore_ev,
                   got.lost_ev);
        return;
      end
      want = expected_q.pop_front();
      if (got.volt_fault !== want.volt_fault || got.freq_fault !== want.freq_fault ||
          got.grid_ok !== want.grid_ok || got.restore_ev !== want.restore_ev ||
          got.lost_ev !== want.lost_ev) begin
        errors++;
        if (errors <= 10)
          $display("status mismatch: expected vf=%0b ff=%0b ok=%0b rst=%0b lost=%0b, %s",
                   want.volt_fault, want.freq_fault, want.grid_ok, want.restore_ev,
                   want.lost_ev,
                   $sformatf("got vf=%0b ff=%0b ok=%0b rst=%0b lost=%0b",
                             got.volt_fault, got.freq_fault, got.grid_ok,
                             got.restore_ev, got.lost_ev));
      end
    endfunction
  endclass

  localparam int unsigned STALL_LIMIT = 2000;  // cycles without any transfer

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0] cfg_data;

  gvff_in_if  in_ch ();
  gvff_out_if out_ch ();

  grid_volt_freq_fault_qualifier uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  status_tracker sb = new();

  // idle percentages of the two sides, and a long result hold-off request
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_len = 0;
  int unsigned quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result side: random stalls, or a long hold-off counted down here while
  // the sender keeps offering, so the block fills and pushes back on input
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        out_ch.ready <= 1'b0;
        hold_len = hold_len - 1;
      end else begin
        out_ch.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // every result transfer is checked against the oldest expected status
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_status('{volt_fault: out_ch.volt_fault, freq_fault: out_ch.freq_fault,
                        grid_ok: out_ch.grid_ok, restore_ev: out_ch.restore_event,
                        lost_ev: out_ch.lost_event});
  end

  // watchdog: any transfer on either side restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one item, idling first at random; valid stays high afterwards so
  // back-to-back items need no low pulse
  task automatic send_item(input mon_item_t it);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= it.kind;
    in_ch.rms_volt   <= it.rms;
    in_ch.line_freq  <= it.freq;
    in_ch.wave_fault <= it.wave;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_item(it);
  endtask

  // stop offering and wait until every expected status has come out,
  // then let the two-stage pipe settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write all eight thresholds on consecutive edges, enable held high
  task automatic load_thresholds(input thr_set_t vals);
    gvff_reg_t r;
    r = r.first();
    repeat (8) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= r;
      cfg_data <= vals[r];
      sb.set_threshold(r, vals[r]);
      @(posedge clk);
      r = r.next();
    end
    cfg_we <= 1'b0;
  endtask

  function automatic mon_item_t tick(logic [RMS_W-1:0] r, logic [FREQ_W-1:0] f, logic w);
    return '{kind: KIND_TICK, rms: r, freq: f, wave: w};
  endfunction

  // a value inside [lo, hi], endpoints favored; anything if the window is empty
  function automatic logic [FREQ_W-1:0] in_window(logic [FREQ_W-1:0] lo, hi, maxv);
    if (lo > hi) return FREQ_W'($urandom_range(maxv, 0));
    case ($urandom_range(7))
      0:       return lo;
      1:       return hi;
      default: return FREQ_W'($urandom_range(hi, lo));
    endcase
  endfunction

  // a value outside [lo_f, hi_f], sometimes just past an edge
  function automatic logic [FREQ_W-1:0] out_window(logic [FREQ_W-1:0] lo_f, hi_f, maxv);
    logic go_high;
    go_high = (hi_f < maxv) && (lo_f == 0 || $urandom_range(1));
    if (go_high) begin
      if ($urandom_range(5) == 0) return hi_f + 1'b1;
      return FREQ_W'($urandom_range(maxv, hi_f + 1));
    end
    if (lo_f > 0) begin
      if ($urandom_range(5) == 0) return lo_f - 1'b1;
      return FREQ_W'($urandom_range(lo_f - 1, 0));
    end
    return FREQ_W'($urandom_range(maxv, 0));
  endfunction

  // runs of well-formed conditions long enough to cross the fault and
  // recovery counts, with zero crossings sprinkled in and some plain noise
  task automatic run_random(input int unsigned n);
    int unsigned       sent, run_len, regime, k;
    logic [RMS_W-1:0]  r;
    logic [FREQ_W-1:0] f;
    logic              w;
    mon_item_t         it;
    sent = 0;
    while (sent < n) begin
      regime = $urandom_range(99);
      if (regime < 40)
        run_len = $urandom_range(1) ? $urandom_range(140, 126) : $urandom_range(60, 1);
      else if (regime < 90)
        run_len = $urandom_range(14, 1);
      else
        run_len = $urandom_range(4, 1);
      for (k = 0; k < run_len && sent < n; k++) begin
        r = RMS_W'(in_window(sb.thr[REG_RMS_LOW_RECOVER], sb.thr[REG_RMS_HIGH_RECOVER],
                             FREQ_W'((1 << RMS_W) - 1)));
        f = in_window(sb.thr[REG_FREQ_LOW_RECOVER], sb.thr[REG_FREQ_HIGH_RECOVER],
                      FREQ_W'((1 << FREQ_W) - 1));
        w = 1'b0;
        if (regime >= 40 && regime < 60) begin
          // voltage out of the fault window
          r = RMS_W'(out_window(sb.thr[REG_RMS_LOW_FAULT], sb.thr[REG_RMS_HIGH_FAULT],
                                FREQ_W'((1 << RMS_W) - 1)));
        end else if (regime >= 60 && regime < 75) begin
          // frequency out of the fault window
          f = out_window(sb.thr[REG_FREQ_LOW_FAULT], sb.thr[REG_FREQ_HIGH_FAULT],
                         FREQ_W'((1 << FREQ_W) - 1));
        end else if (regime >= 75 && regime < 83) begin
          // voltage under the frequency gate
          r = RMS_W'($urandom_range(FREQ_GATE_VOLT - 1, 0));
          f = FREQ_W'($urandom);
        end else if (regime >= 83 && regime < 90) begin
          w = 1'b1;
        end else if (regime >= 90) begin
          r = RMS_W'($urandom);
          f = FREQ_W'($urandom);
          w = 1'($urandom_range(1));
        end
        it = tick(r, f, w);
        if ((regime >= 90) ? ($urandom_range(1) == 0) : ($urandom_range(9) == 0))
          it.kind = KIND_ZC;
        send_item(it);
        sent++;
      end
    end
  endtask

  initial begin
    mon_item_t zc_item;
    int unsigned k;

    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_idx          <= REG_RMS_HIGH_FAULT;
    cfg_data         <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.kind       <= KIND_TICK;
    in_ch.rms_volt   <= '0;
    in_ch.line_freq  <= '0;
    in_ch.wave_fault <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part on reset thresholds, no idling
    // grid comes up, then drops on a waveform fault: restore and lost armed
    // together, and a zero crossing fires both; the drop also forces the
    // voltage fault
    send_item(tick(15'd1500, 16'd550, 1'b0));
    send_item(tick(15'd1500, 16'd550, 1'b1));
    zc_item = '{kind: KIND_ZC, rms: '1, freq: '1, wave: 1'b1};
    send_item(zc_item);
    // field extremes; zero crossing with nothing pending
    send_item(tick('0, '0, 1'b0));
    send_item(tick('1, '1, 1'b1));
    zc_item = '{kind: KIND_ZC, rms: '0, freq: '0, wave: 1'b0};
    send_item(zc_item);
    // frequency fault qualifies after the full fault count
    for (k = 0; k < 10; k++) send_item(tick(15'd1500, 16'd700, 1'b0));
    // frequency gate edges: just below clears the fault, at the gate counts
    send_item(tick(FREQ_GATE_VOLT - 1'b1, 16'hFFFF, 1'b0));
    send_item(tick(FREQ_GATE_VOLT, 16'h0000, 1'b0));
    send_item(tick(15'd2700, 16'd650, 1'b0));
    send_item(tick(15'd2701, 16'd449, 1'b0));

    run_random(300);
    drain();

    // shifted windows, rms high limits written with the top bit set
    send_idle_pct = 57;
    load_thresholds('{16'h8BB8, 16'd1000, 16'h8B54, 16'd1100,
                      16'd1000, 16'd200, 16'd900, 16'd300});
    run_random(250);
    drain();

    // widest windows: nothing faults, recovery always counts
    send_idle_pct  = 0;
    recv_stall_pct = 57;
    load_thresholds('{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000,
                      16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000});
    run_random(150);
    drain();

    // all-zero windows: any nonzero value is out, only zero recovers
    send_idle_pct  = 23;
    recv_stall_pct = 23;
    load_thresholds('{16'h0000, 16'h0000, 16'h0000, 16'h0000,
                      16'h0000, 16'h0000, 16'h0000, 16'h0000});
    run_random(100);
    drain();

    // reset values written back; long result hold-off under full input load
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    load_thresholds('{{1'b0, RMS_HIGH_FAULT_RST}, {1'b0, RMS_LOW_FAULT_RST},
                      {1'b0, RMS_HIGH_RECOVER_RST}, {1'b0, RMS_LOW_RECOVER_RST},
                      FREQ_HIGH_FAULT_RST, FREQ_LOW_FAULT_RST,
                      FREQ_HIGH_RECOVER_RST, FREQ_LOW_RECOVER_RST});
    hold_len = 300;
    run_random(120);
    send_idle_pct  = 23;
    recv_stall_pct = 23;
    run_random(130);
    drain();

    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
